@@ rtl/pgmb_pkg.sv @@
// Shared types, constants and register codes for the point grid max binning block.
`default_nettype none
package pgmb_pkg;
  localparam int MaxCols = 256;
  localparam int MaxRows = 256;
  localparam int NumCells = MaxCols * MaxRows;
  localparam int AddrW = $clog2(NumCells);

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_READ = 2'd1,
    KIND_READ_CLR = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    REG_X_ORIGIN = 3'd0,
    REG_Y_TOP = 3'd1,
    REG_CELL_X = 3'd2,
    REG_CELL_Y = 3'd3,
    REG_GRID_COLS = 3'd4,
    REG_GRID_ROWS = 3'd5
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_WAIT,
    ST_WRITE,
    ST_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_step;
    logic load;
    logic div_step;
    logic mem_read;
    logic mem_write;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_done;
    logic div_done;
  } sts_t;
endpackage
`default_nettype wire

@@ rtl/pgmb_ctrl.sv @@
// Controller state machine sequencing clear, divide, memory access and output.
`default_nettype none
module pgmb_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  output pgmb_pkg::cmd_t      cmd,
  input  wire pgmb_pkg::sts_t sts
);
  pgmb_pkg::state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  // State and output valid registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pgmb_pkg::ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pgmb_pkg::ST_CLEAR: if (sts.clr_done) state_nxt = pgmb_pkg::ST_IDLE;
      pgmb_pkg::ST_IDLE: if (in_valid) state_nxt = pgmb_pkg::ST_DIV;
      pgmb_pkg::ST_DIV: if (sts.div_done) state_nxt = pgmb_pkg::ST_READ;
      pgmb_pkg::ST_READ: state_nxt = pgmb_pkg::ST_WAIT;
      pgmb_pkg::ST_WAIT: state_nxt = pgmb_pkg::ST_WRITE;
      pgmb_pkg::ST_WRITE: state_nxt = pgmb_pkg::ST_OUT;
      pgmb_pkg::ST_OUT: if (!out_valid_r || out_ready) state_nxt = pgmb_pkg::ST_IDLE;
      default: state_nxt = pgmb_pkg::ST_IDLE;
    endcase
  end

  // Outputs and commands.
  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      pgmb_pkg::ST_CLEAR: cmd.clr_step = 1'b1;
      pgmb_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      pgmb_pkg::ST_DIV: cmd.div_step = 1'b1;
      pgmb_pkg::ST_READ: cmd.mem_read = 1'b1;
      pgmb_pkg::ST_WRITE: cmd.mem_write = 1'b1;
      pgmb_pkg::ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
endmodule
`default_nettype wire

@@ rtl/pgmb_datapath.sv @@
// Datapath: config registers, serial dividers, cell memory and result register.
`default_nettype none
module pgmb_datapath (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire pgmb_pkg::cmd_t  cmd,
  output pgmb_pkg::sts_t       sts,
  input  wire logic            cfg_valid,
  input  wire logic [2:0]      cfg_index,
  input  wire logic [31:0]     cfg_data,
  input  wire logic [1:0]      in_kind,
  input  wire logic [31:0]     in_point_x,
  input  wire logic [31:0]     in_point_y,
  input  wire logic [31:0]     in_point_z,
  input  wire logic [7:0]      in_cell_row,
  input  wire logic [7:0]      in_cell_col,
  output logic                 out_in_grid,
  output logic [7:0]           out_row_out,
  output logic [7:0]           out_col_out,
  output logic                 out_has_data,
  output logic [31:0]          out_height_raw
);
  localparam int AW = pgmb_pkg::AddrW;

  logic [31:0] x_origin_r, y_top_r, cell_x_r, cell_y_r;
  logic [8:0]  cols_r, rows_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_origin_r <= '0;
      y_top_r <= '0;
      cell_x_r <= 32'd1;
      cell_y_r <= 32'd1;
      cols_r <= 9'd256;
      rows_r <= 9'd256;
    end else if (cfg_valid) begin
      case (pgmb_pkg::reg_idx_t'(cfg_index))
        pgmb_pkg::REG_X_ORIGIN: x_origin_r <= cfg_data;
        pgmb_pkg::REG_Y_TOP: y_top_r <= cfg_data;
        pgmb_pkg::REG_CELL_X: cell_x_r <= cfg_data;
        pgmb_pkg::REG_CELL_Y: cell_y_r <= cfg_data;
        pgmb_pkg::REG_GRID_COLS: cols_r <= cfg_data[8:0];
        pgmb_pkg::REG_GRID_ROWS: rows_r <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // Clamp grid size to the memory geometry.
  logic [8:0] used_cols, used_rows;
  assign used_cols = (cols_r > 9'(pgmb_pkg::MaxCols)) ? 9'(pgmb_pkg::MaxCols) : cols_r;
  assign used_rows = (rows_r > 9'(pgmb_pkg::MaxRows)) ? 9'(pgmb_pkg::MaxRows) : rows_r;

  // Item registers. Magnitudes of the differences feed restoring dividers.
  logic [1:0]  kind_r;
  logic [31:0] z_r;
  logic [7:0]  rq_row_r, rq_col_r;
  logic        negx_r, negy_r;
  logic [32:0] qx_r, qy_r;
  logic [32:0] rx_r, ry_r;
  logic [31:0] dx_r, dy_r;
  logic [5:0]  cnt_r;
  logic [32:0] diffx, diffy;

  assign diffx = {1'b0, in_point_x} - {1'b0, x_origin_r};
  assign diffy = {1'b0, y_top_r} - {1'b0, in_point_y};

  logic [33:0] trx, try_;
  assign trx = {rx_r, qx_r[32]} - {2'b00, dx_r};
  assign try_ = {ry_r, qy_r[32]} - {2'b00, dy_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.load) begin
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      cnt_r <= cnt_r + 6'd1;
    end
  end

  // One quotient bit per cycle for each axis.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_kind;
      z_r <= in_point_z;
      rq_row_r <= in_cell_row;
      rq_col_r <= in_cell_col;
      negx_r <= diffx[32];
      negy_r <= diffy[32];
      qx_r <= diffx[32] ? (~diffx + 33'd1) : diffx;
      qy_r <= diffy[32] ? (~diffy + 33'd1) : diffy;
      rx_r <= '0;
      ry_r <= '0;
      dx_r <= (cell_x_r == '0) ? 32'd1 : cell_x_r;
      dy_r <= (cell_y_r == '0) ? 32'd1 : cell_y_r;
    end else if (cmd.div_step && !sts.div_done) begin
      if (!trx[33]) begin
        rx_r <= trx[32:0];
        qx_r <= {qx_r[31:0], 1'b1};
      end else begin
        rx_r <= {rx_r[31:0], qx_r[32]};
        qx_r <= {qx_r[31:0], 1'b0};
      end
      if (!try_[33]) begin
        ry_r <= try_[32:0];
        qy_r <= {qy_r[31:0], 1'b1};
      end else begin
        ry_r <= {ry_r[31:0], qy_r[32]};
        qy_r <= {qy_r[31:0], 1'b0};
      end
    end
  end

  // A negative quotient is in the grid only when it truncates to zero.
  // The 33-bit loop runs 33 steps; DIV exits in the cycle after the last step.
  logic        x_ok, y_ok, pt_in, rd_in, hit;
  logic [7:0]  row_sel, col_sel;
  assign x_ok = ((qx_r == '0) || !negx_r) && (qx_r < {24'd0, used_cols});
  assign y_ok = ((qy_r == '0) || !negy_r) && (qy_r < {24'd0, used_rows});
  assign pt_in = x_ok && y_ok;
  assign rd_in = ({1'b0, rq_row_r} < used_rows) && ({1'b0, rq_col_r} < used_cols);
  assign row_sel = (kind_r == pgmb_pkg::KIND_INSERT) ? qy_r[7:0] : rq_row_r;
  assign col_sel = (kind_r == pgmb_pkg::KIND_INSERT) ? qx_r[7:0] : rq_col_r;
  assign hit = (kind_r == pgmb_pkg::KIND_INSERT) ? pt_in :
               ((kind_r == pgmb_pkg::KIND_READ || kind_r == pgmb_pkg::KIND_READ_CLR)
                && rd_in);

  // Cell memory with a valid-bit memory that is swept clear after reset.
  logic [31:0] height_mem [pgmb_pkg::NumCells];
  logic        valid_mem  [pgmb_pkg::NumCells];
  logic [AW:0] clr_r;
  logic [31:0] h_rd_r;
  logic        v_rd_r;
  logic [AW-1:0] addr;
  assign addr = {row_sel, col_sel};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clr_step && !clr_r[AW]) begin
      clr_r <= clr_r + 1'b1;
    end
  end

  // Status back to the controller.
  assign sts = '{clr_done: clr_r[AW], div_done: (cnt_r == 6'd33)};

  always_ff @(posedge clk) begin
    if (cmd.mem_read) begin
      h_rd_r <= height_mem[addr];
      v_rd_r <= valid_mem[addr];
    end
  end

  logic upd;
  assign upd = !v_rd_r || (z_r > h_rd_r);

  always_ff @(posedge clk) begin
    if (cmd.clr_step && !clr_r[AW]) begin
      valid_mem[clr_r[AW-1:0]] <= 1'b0;
    end else if (cmd.mem_write && hit) begin
      if (kind_r == pgmb_pkg::KIND_INSERT) begin
        if (upd) valid_mem[addr] <= 1'b1;
      end else if (kind_r == pgmb_pkg::KIND_READ_CLR) begin
        valid_mem[addr] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_write && hit && kind_r == pgmb_pkg::KIND_INSERT && upd) begin
      height_mem[addr] <= z_r;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_in_grid <= hit;
      out_row_out <= (hit || kind_r != pgmb_pkg::KIND_INSERT) &&
                     kind_r != pgmb_pkg::KIND_NONE ? row_sel : 8'd0;
      out_col_out <= (hit || kind_r != pgmb_pkg::KIND_INSERT) &&
                     kind_r != pgmb_pkg::KIND_NONE ? col_sel : 8'd0;
      if (kind_r == pgmb_pkg::KIND_INSERT) begin
        out_has_data <= hit;
        out_height_raw <= !hit ? 32'd0 : (upd ? z_r : h_rd_r);
      end else begin
        out_has_data <= hit && v_rd_r;
        out_height_raw <= (hit && v_rd_r) ? h_rd_r : 32'd0;
      end
    end
  end
endmodule
`default_nettype wire

@@ rtl/point_grid_max_binning.sv @@
// Top level of the point grid max binning block.
// Usage:
// - The input channel (in_valid/in_ready) takes one transaction per item:
//   kind 0 inserts a raw point, kind 1 reads a cell, kind 2 reads and clears it.
// - The output channel (out_valid/out_ready) returns exactly one transaction
//   per item, in order.
// - The configuration channel (cfg_valid/cfg_ready) writes register cfg_index
//   with cfg_data; it is always ready and is meant to be used while idle.
// - Each item runs from acceptance to result through the bit-serial restoring
//   dividers that form the column and row (33 quotient steps, then the exit
//   from DIV), then memory read, read latency, write-back and result load.
//   The next item is taken in the cycle after the result is loaded into the
//   output register, so the block takes no new item while one is in flight.
// - After reset the valid-bit memory is swept, one cell per cycle, over all
//   65536 cells; no item is accepted during the sweep.
// - When the receiver stalls, the result holds in the output register; the
//   block can take one more item, then waits with in_ready low in ST_OUT.
`default_nettype none
module point_grid_max_binning (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_kind,
  input  wire logic [31:0] in_point_x,
  input  wire logic [31:0] in_point_y,
  input  wire logic [31:0] in_point_z,
  input  wire logic [7:0]  in_cell_row,
  input  wire logic [7:0]  in_cell_col,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_in_grid,
  output logic [7:0]       out_row_out,
  output logic [7:0]       out_col_out,
  output logic             out_has_data,
  output logic [31:0]      out_height_raw
);
  pgmb_pkg::cmd_t cmd;
  pgmb_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  pgmb_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .cmd(cmd), .sts(sts)
  );

  pgmb_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_kind(in_kind), .in_point_x(in_point_x), .in_point_y(in_point_y),
    .in_point_z(in_point_z), .in_cell_row(in_cell_row), .in_cell_col(in_cell_col),
    .out_in_grid(out_in_grid), .out_row_out(out_row_out), .out_col_out(out_col_out),
    .out_has_data(out_has_data), .out_height_raw(out_height_raw)
  );
endmodule
`default_nettype wire
